FILE: rtl/core/tpsd_pkg.sv
// Shared types, codes and helpers for the typed parameter stream decoder.
`default_nettype none
package tpsd_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_OBJID  = 3'd2,
      PH_TYPE   = 3'd3,
      PH_FORMAT = 3'd4,
      PH_COUNT  = 3'd5,
      PH_DATA   = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   localparam logic [7:0] HEADER_SKIP_RESET = 8'd12;
   localparam int unsigned OBJID_BYTES = 4;

   localparam logic [7:0] TYPE_BOOL   = 8'd1;
   localparam logic [7:0] TYPE_UINT   = 8'd3;
   localparam logic [7:0] TYPE_SINT   = 8'd4;
   localparam logic [7:0] TYPE_REAL   = 8'd5;
   localparam logic [7:0] TYPE_STRING = 8'd8;

   localparam logic [7:0] FMT_BOOL       = 8'd0;
   localparam logic [7:0] FMT_REAL32     = 8'd1;
   localparam logic [7:0] FMT_REAL64     = 8'd2;
   localparam logic [7:0] FMT_REAL32_ALT = 8'd3;
   localparam logic [7:0] FMT_INT8       = 8'd4;
   localparam logic [7:0] FMT_INT16      = 8'd12;
   localparam logic [7:0] FMT_INT32      = 8'd14;
   localparam logic [7:0] FMT_INT64      = 8'd16;

   localparam logic [7:0] LEN_1 = 8'd1;
   localparam logic [7:0] LEN_2 = 8'd2;
   localparam logic [7:0] LEN_4 = 8'd4;
   localparam logic [7:0] LEN_8 = 8'd8;

   typedef struct packed {
      logic [63:0] value;
      logic [31:0] object_id;
      logic [7:0]  type_code;
      logic [7:0]  format_code;
      logic [7:0]  element_index;
      logic        last;
   } result_type;

   function automatic logic is_int_format(input logic [7:0] fmt);
      return (fmt == FMT_INT8) || (fmt == FMT_INT16) || (fmt == FMT_INT32) ||
             (fmt == FMT_INT64);
   endfunction

   function automatic logic [7:0] int_length(input logic [7:0] fmt);
      logic [7:0] len;
      case (fmt)
         FMT_INT16: len = LEN_2;
         FMT_INT32: len = LEN_4;
         FMT_INT64: len = LEN_8;
         default:   len = LEN_1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] element_length(input logic [7:0] typ,
                                                 input logic [7:0] fmt);
      logic [7:0] len;
      len = LEN_1;
      if ((typ == TYPE_UINT) || (typ == TYPE_SINT)) begin
         len = int_length(fmt);
      end else if (typ == TYPE_REAL) begin
         if ((fmt == FMT_REAL32) || (fmt == FMT_REAL32_ALT)) begin
            len = LEN_4;
         end else if (fmt == FMT_REAL64) begin
            len = LEN_8;
         end
      end else if ((typ == TYPE_STRING) && (fmt != FMT_BOOL)) begin
         len = fmt;
      end
      return len;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tpsd_parser.sv
// Packet field sequencer and element assembler, one byte per transfer.
`default_nettype none
module tpsd_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire  [7:0]            packet_byte,
   input  wire                   first,
   input  wire  [7:0]            header_skip,
   output logic                  res_valid,
   output tpsd_pkg::result_type  res
);
   import tpsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  header_count_ff, header_count_in;
   logic [31:0] object_id_ff, object_id_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  format_ff, format_in;
   logic [7:0]  elements_left_ff, elements_left_in;
   logic [7:0]  element_length_ff, element_length_in;
   logic [7:0]  byte_in_element_ff, byte_in_element_in;
   logic [63:0] accumulator_ff, accumulator_in;
   logic [7:0]  index_ff, index_in;

   phase_type   phase_cur;
   logic [7:0]  header_count_cur;
   logic [31:0] object_id_cur;
   logic [7:0]  type_cur;
   logic [7:0]  format_cur;
   logic [7:0]  elements_left_cur;
   logic [7:0]  element_length_cur;
   logic [7:0]  byte_in_element_cur;
   logic [63:0] accumulator_cur;
   logic [7:0]  index_cur;
   logic [63:0] acc_next;
   logic [7:0]  byte_next;
   logic [7:0]  left_next;
   logic [63:0] dec_value;
   logic        dec_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         header_count_ff    <= '0;
         object_id_ff       <= '0;
         type_ff            <= '0;
         format_ff          <= '0;
         elements_left_ff   <= '0;
         element_length_ff  <= LEN_1;
         byte_in_element_ff <= '0;
         accumulator_ff     <= '0;
         index_ff           <= '0;
      end else if (accept) begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         object_id_ff       <= object_id_in;
         type_ff            <= type_in;
         format_ff          <= format_in;
         elements_left_ff   <= elements_left_in;
         element_length_ff  <= element_length_in;
         byte_in_element_ff <= byte_in_element_in;
         accumulator_ff     <= accumulator_in;
         index_ff           <= index_in;
      end
   end

   always_comb begin
      phase_cur           = phase_ff;
      header_count_cur    = header_count_ff;
      object_id_cur       = object_id_ff;
      type_cur            = type_ff;
      format_cur          = format_ff;
      elements_left_cur   = elements_left_ff;
      element_length_cur  = element_length_ff;
      byte_in_element_cur = byte_in_element_ff;
      accumulator_cur     = accumulator_ff;
      index_cur           = index_ff;
      if (first) begin
         phase_cur           = (header_skip == '0) ? PH_OBJID : PH_HEADER;
         header_count_cur    = '0;
         object_id_cur       = '0;
         type_cur            = '0;
         format_cur          = '0;
         elements_left_cur   = '0;
         element_length_cur  = LEN_1;
         byte_in_element_cur = '0;
         accumulator_cur     = '0;
         index_cur           = '0;
      end
   end

   assign acc_next  = {accumulator_cur[55:0], packet_byte};
   assign byte_next = byte_in_element_cur + 8'd1;
   assign left_next = elements_left_cur - 8'd1;

   always_comb begin
      dec_ok    = 1'b0;
      dec_value = acc_next;
      if ((type_cur == TYPE_BOOL) && (format_cur == FMT_BOOL)) begin
         dec_ok    = 1'b1;
         dec_value = {63'd0, (acc_next != '0)};
      end else if (((type_cur == TYPE_UINT) || (type_cur == TYPE_SINT)) &&
                   is_int_format(format_cur)) begin
         dec_ok = 1'b1;
         if (type_cur == TYPE_SINT) begin
            case (element_length_cur)
               LEN_1:   dec_value = {{56{acc_next[7]}}, acc_next[7:0]};
               LEN_2:   dec_value = {{48{acc_next[15]}}, acc_next[15:0]};
               LEN_4:   dec_value = {{32{acc_next[31]}}, acc_next[31:0]};
               default: dec_value = acc_next;
            endcase
         end
      end else if ((type_cur == TYPE_REAL) &&
                   ((format_cur == FMT_REAL32) || (format_cur == FMT_REAL64) ||
                    (format_cur == FMT_REAL32_ALT))) begin
         dec_ok = 1'b1;
      end
   end

   always_comb begin
      phase_in           = phase_cur;
      header_count_in    = header_count_cur;
      object_id_in       = object_id_cur;
      type_in            = type_cur;
      format_in          = format_cur;
      elements_left_in   = elements_left_cur;
      element_length_in  = element_length_cur;
      byte_in_element_in = byte_in_element_cur;
      accumulator_in     = accumulator_cur;
      index_in           = index_cur;
      res_valid          = 1'b0;
      res.value          = dec_value;
      res.object_id      = object_id_cur;
      res.type_code      = type_cur;
      res.format_code    = format_cur;
      res.element_index  = index_cur;
      res.last           = (left_next == '0);
      unique case (phase_cur)
         PH_HEADER: begin
            header_count_in = header_count_cur + 8'd1;
            if (header_count_in == header_skip) begin
               phase_in        = PH_OBJID;
               header_count_in = '0;
            end
         end
         PH_OBJID: begin
            object_id_in    = {object_id_cur[23:0], packet_byte};
            header_count_in = header_count_cur + 8'd1;
            if (header_count_in >= 8'(OBJID_BYTES)) begin
               phase_in        = PH_TYPE;
               header_count_in = '0;
            end
         end
         PH_TYPE: begin
            type_in  = packet_byte;
            phase_in = PH_FORMAT;
         end
         PH_FORMAT: begin
            format_in         = packet_byte;
            element_length_in = element_length(type_cur, packet_byte);
            phase_in          = PH_COUNT;
         end
         PH_COUNT: begin
            elements_left_in   = packet_byte;
            index_in           = '0;
            byte_in_element_in = '0;
            accumulator_in     = '0;
            phase_in           = (packet_byte == '0) ? PH_DONE : PH_DATA;
         end
         PH_DATA: begin
            accumulator_in     = acc_next;
            byte_in_element_in = byte_next;
            if (byte_next >= element_length_cur) begin
               elements_left_in   = left_next;
               res_valid          = dec_ok;
               index_in           = index_cur + 8'd1;
               byte_in_element_in = '0;
               accumulator_in     = '0;
               if (left_next == '0) begin
                  phase_in = PH_DONE;
               end
            end
         end
         PH_IDLE, PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/core/typed_parameter_stream_decoder_core.sv
// Top level of the typed parameter stream decoder: CSR, parser and result buffering.
`default_nettype none
// Takes one packet byte per transfer and can accept a byte in every cycle while
// req_stall is low; each byte is parsed in one pass, and on an element's last byte
// its result is registered for rsp_. A result register backed by a one-entry skid
// buffer decouples the sides: req_stall rises only once the skid holds a result,
// i.e. after the result side has stalled with two results pending. header_skip is
// written through csr_ and should change only between packets. Elements of
// undecodable type are consumed and give no transfer.
module typed_parameter_stream_decoder_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write_enable,
   input  wire  [7:0]  csr_write_data,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_packet_byte,
   input  wire         req_first,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [63:0] rsp_value,
   output logic [31:0] rsp_object_id,
   output logic [7:0]  rsp_type_code,
   output logic [7:0]  rsp_format_code,
   output logic [7:0]  rsp_element_index,
   output logic        rsp_last
);
   import tpsd_pkg::*;

   logic [7:0] header_skip_ff;
   logic       accept;
   logic       take;
   logic       gen;
   logic       res_valid;
   result_type res;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign gen       = accept && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= HEADER_SKIP_RESET;
      end else if (csr_write_enable) begin
         header_skip_ff <= csr_write_data;
      end
   end

   tpsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .packet_byte (req_packet_byte),
      .first       (req_first),
      .header_skip (header_skip_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (gen) begin
         if (!out_valid_ff || take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_value         = out_ff.value;
   assign rsp_object_id     = out_ff.object_id;
   assign rsp_type_code     = out_ff.type_code;
   assign rsp_format_code   = out_ff.format_code;
   assign rsp_element_index = out_ff.element_index;
   assign rsp_last          = out_ff.last;

endmodule
`default_nettype wire

FILE: rtl/core/tpsd_checker.sv
// Port-level assertions for the typed parameter stream decoder, bound to the top level.
`default_nettype none
module tpsd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        req_first,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [63:0] rsp_value,
   input wire        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall pending after reset");

   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_valid))
      else $error("request stalled without a pending result");

   a_first_no_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_first && !rsp_valid |=> !rsp_valid)
      else $error("first packet byte produced a result");

endmodule

bind typed_parameter_stream_decoder_core tpsd_checker u_tpsd_checker (.*);
`default_nettype wire

FILE: test/typed_parameter_stream_decoder_core_tb.sv
// Self-checking testbench for the typed parameter stream decoder core.
module typed_parameter_stream_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpsd_pkg::*;

   localparam int IDLE_PCT     = 23;
   localparam int HOLD_CYCLES  = 120;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_packet_byte = 8'd0;
   logic        req_first = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic [31:0] rsp_object_id;
   logic [7:0]  rsp_type_code;
   logic [7:0]  rsp_format_code;
   logic [7:0]  rsp_element_index;
   logic        rsp_last;

   typed_parameter_stream_decoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packet_byte   (req_packet_byte),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_object_id     (rsp_object_id),
      .rsp_type_code     (rsp_type_code),
      .rsp_format_code   (rsp_format_code),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   stream_byte_type byte_stream[$];
   result_type      decoded_due[$];

   int cycle_count = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int elements_checked = 0;
   int packets_built = 0;
   int stall_cycles = 0;
   int send_idle_pct = IDLE_PCT;
   int recv_idle_pct = IDLE_PCT;
   bit hold_request = 1'b0;

   // decoder state mirrored by the predictor
   logic [7:0]  cfg_skip = HEADER_SKIP_RESET;
   phase_type   dec_phase = PH_IDLE;
   logic [7:0]  hdr_count = 8'd0;
   logic [31:0] obj_id = 32'd0;
   logic [7:0]  typ_q = 8'd0;
   logic [7:0]  fmt_q = 8'd0;
   logic [7:0]  elems_left = 8'd0;
   logic [7:0]  elem_len = LEN_1;
   logic [7:0]  byte_idx = 8'd0;
   logic [63:0] acc = 64'd0;
   logic [7:0]  elem_idx = 8'd0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic logic [7:0] elem_bytes(input logic [7:0] typ, input logic [7:0] fmt);
      if (typ == TYPE_UINT || typ == TYPE_SINT) begin
         if (fmt == FMT_INT16) return LEN_2;
         if (fmt == FMT_INT32) return LEN_4;
         if (fmt == FMT_INT64) return LEN_8;
         return LEN_1;
      end
      if (typ == TYPE_REAL) begin
         if (fmt == FMT_REAL32 || fmt == FMT_REAL32_ALT) return LEN_4;
         if (fmt == FMT_REAL64) return LEN_8;
         return LEN_1;
      end
      if (typ == TYPE_STRING && fmt != 8'd0) return fmt;
      return LEN_1;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic first);
      result_type r;
      bit         hit;
      int         bits;
      if (first) begin
         if (cfg_skip == 8'd0) dec_phase = PH_OBJID;
         else dec_phase = PH_HEADER;
         hdr_count = 8'd0;
         obj_id = 32'd0;
         typ_q = 8'd0;
         fmt_q = 8'd0;
         elems_left = 8'd0;
         elem_len = LEN_1;
         byte_idx = 8'd0;
         acc = 64'd0;
         elem_idx = 8'd0;
      end
      case (dec_phase)
         PH_HEADER: begin
            hdr_count = hdr_count + 8'd1;
            if (hdr_count == cfg_skip) begin
               dec_phase = PH_OBJID;
               hdr_count = 8'd0;
            end
         end
         PH_OBJID: begin
            obj_id = {obj_id[23:0], b};
            hdr_count = hdr_count + 8'd1;
            if (hdr_count >= OBJID_BYTES) begin
               dec_phase = PH_TYPE;
               hdr_count = 8'd0;
            end
         end
         PH_TYPE: begin
            typ_q = b;
            dec_phase = PH_FORMAT;
         end
         PH_FORMAT: begin
            fmt_q = b;
            elem_len = elem_bytes(typ_q, fmt_q);
            dec_phase = PH_COUNT;
         end
         PH_COUNT: begin
            elems_left = b;
            elem_idx = 8'd0;
            byte_idx = 8'd0;
            acc = 64'd0;
            if (b == 8'd0) dec_phase = PH_DONE;
            else dec_phase = PH_DATA;
         end
         PH_DATA: begin
            acc = {acc[55:0], b};
            byte_idx = byte_idx + 8'd1;
            if (byte_idx >= elem_len) begin
               elems_left = elems_left - 8'd1;
               hit = 1'b0;
               r.value = acc;
               if (typ_q == TYPE_BOOL && fmt_q == FMT_BOOL) begin
                  r.value = (acc != 64'd0) ? 64'd1 : 64'd0;
                  hit = 1'b1;
               end else if ((typ_q == TYPE_UINT || typ_q == TYPE_SINT) &&
                            (fmt_q == FMT_INT8 || fmt_q == FMT_INT16 ||
                             fmt_q == FMT_INT32 || fmt_q == FMT_INT64)) begin
                  bits = int'(elem_len) * 8;
                  if (typ_q == TYPE_SINT && bits < 64 && acc[bits-1])
                     r.value = acc | ({64{1'b1}} << bits);
                  hit = 1'b1;
               end else if (typ_q == TYPE_REAL &&
                            (fmt_q == FMT_REAL32 || fmt_q == FMT_REAL64 ||
                             fmt_q == FMT_REAL32_ALT)) begin
                  hit = 1'b1;
               end
               if (hit) begin
                  r.object_id = obj_id;
                  r.type_code = typ_q;
                  r.format_code = fmt_q;
                  r.element_index = elem_idx;
                  r.last = (elems_left == 8'd0);
                  decoded_due.push_back(r);
               end
               elem_idx = elem_idx + 8'd1;
               byte_idx = 8'd0;
               acc = 64'd0;
               if (elems_left == 8'd0) dec_phase = PH_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : drive_bytes
      stream_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_byte(req_packet_byte, req_first);
            bytes_sent++;
         end else if (req_valid) begin
            stall_cycles++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_stream.pop_front();
               req_valid <= 1'b1;
               req_packet_byte <= nxt.data;
               req_first <= nxt.first;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      result_type want;
      int         hold_left;
      bit         hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_due.size() == 0) begin
               $error("unexpected result: value %0h index %0d", rsp_value, rsp_element_index);
               error_count++;
            end else begin
               want = decoded_due.pop_front();
               check_field("value", want.value, rsp_value);
               check_field("object_id", 64'(want.object_id), 64'(rsp_object_id));
               check_field("type_code", 64'(want.type_code), 64'(rsp_type_code));
               check_field("format_code", 64'(want.format_code), 64'(rsp_format_code));
               check_field("element_index", 64'(want.element_index),
                           64'(rsp_element_index));
               check_field("last", 64'(want.last), 64'(rsp_last));
               elements_checked++;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         3: return 8'h7F;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic first);
      stream_byte_type s;
      s.data = b;
      s.first = first;
      byte_stream.push_back(s);
   endtask

   task automatic push_fields(input logic [31:0] obj, input logic [7:0] typ,
                              input logic [7:0] fmt, input logic [7:0] count);
      bit lead;
      lead = 1'b1;
      for (int i = 0; i < int'(cfg_skip); i++) begin
         push_byte(pick_byte(), lead);
         lead = 1'b0;
      end
      for (int i = 3; i >= 0; i--) begin
         push_byte(obj[8*i +: 8], lead);
         lead = 1'b0;
      end
      push_byte(typ, 1'b0);
      push_byte(fmt, 1'b0);
      push_byte(count, 1'b0);
      packets_built++;
   endtask

   task automatic add_packet(input logic [7:0] typ, input logic [7:0] fmt,
                             input logic [7:0] count, input bit may_cut);
      int start;
      int keep;
      start = byte_stream.size();
      push_fields($urandom, typ, fmt, count);
      repeat (int'(elem_bytes(typ, fmt)) * int'(count)) push_byte(pick_byte(), 1'b0);
      if (may_cut && $urandom_range(99) < 12) begin
         keep = $urandom_range(byte_stream.size() - start - 1, 1);
         while (byte_stream.size() > start + keep) void'(byte_stream.pop_back());
      end
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(3, 1)) push_byte(pick_byte(), 1'b0);
   endtask

   task automatic pick_codes(output logic [7:0] typ, output logic [7:0] fmt);
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         typ = TYPE_BOOL;
         fmt = FMT_BOOL;
      end else if (r < 60) begin
         typ = (r < 35) ? TYPE_UINT : TYPE_SINT;
         case ($urandom_range(3))
            0: fmt = FMT_INT8;
            1: fmt = FMT_INT16;
            2: fmt = FMT_INT32;
            default: fmt = FMT_INT64;
         endcase
      end else if (r < 75) begin
         typ = TYPE_REAL;
         case ($urandom_range(2))
            0: fmt = FMT_REAL32;
            1: fmt = FMT_REAL64;
            default: fmt = FMT_REAL32_ALT;
         endcase
      end else if (r < 82) begin
         typ = TYPE_STRING;
         fmt = 8'($urandom_range(6));
      end else begin
         // known and unknown types with arbitrary formats
         case ($urandom_range(4))
            0: typ = TYPE_BOOL;
            1: typ = TYPE_UINT;
            2: typ = TYPE_SINT;
            3: typ = TYPE_REAL;
            default: typ = 8'($urandom);
         endcase
         fmt = 8'($urandom);
         if (typ == TYPE_STRING) fmt = {4'd0, fmt[3:0]};
      end
   endtask

   task automatic fill_random(input int budget);
      logic [7:0] typ;
      logic [7:0] fmt;
      logic [7:0] count;
      int         r;
      while (byte_stream.size() < budget) begin
         pick_codes(typ, fmt);
         r = $urandom_range(99);
         if (r < 6) count = 8'd0;
         else if (r < 80) count = 8'($urandom_range(4, 1));
         else if (r < 95) count = 8'($urandom_range(12, 5));
         else count = 8'($urandom_range(40, 13));
         add_packet(typ, fmt, count, 1'b1);
      end
   endtask

   task automatic set_skip(input logic [7:0] v);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_skip = v;
      @(negedge clock);
   endtask

   task automatic drain_all();
      @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || decoded_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : run_stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_skip(8'd0);
      // drop: stray byte with no packet open
      push_byte(8'h5A, 1'b0);
      push_fields(32'hFFFF_FFFF, TYPE_SINT, FMT_INT8, 8'd2);
      push_byte(8'h80, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_fields(32'h0000_0000, TYPE_BOOL, FMT_BOOL, 8'd0);
      // undecodable final element: two-byte string
      push_fields(32'h0000_0001, TYPE_STRING, 8'd2, 8'd1);
      push_byte(8'hC3, 1'b0);
      push_byte(8'h3C, 1'b0);
      drain_all();

      fill_random(250);
      drain_all();

      set_skip(8'd255);
      fill_random(300);
      drain_all();

      set_skip(8'd1);
      fill_random(180);
      drain_all();

      set_skip(8'($urandom_range(20, 2)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_random(180);
      drain_all();
      recv_idle_pct = IDLE_PCT;

      // hold the result side while a long boolean packet streams in
      hold_request = 1'b1;
      add_packet(TYPE_BOOL, FMT_BOOL, 8'd255, 1'b0);
      drain_all();
      send_idle_pct = IDLE_PCT;

      set_skip(HEADER_SKIP_RESET);
      fill_random(180);
      drain_all();

      if (decoded_due.size() != 0) begin
         $error("%0d expected elements never arrived", decoded_due.size());
         error_count++;
      end
      $display("covered %0d bytes in %0d packets, header skips 0/1/12/255 and one random",
               bytes_sent, packets_built);
      $display("checked %0d decoded elements, %0d cycles of input back-pressure",
               elements_checked, stall_cycles);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
